/* sv/tsmix_pkg.sv */
// Shared types, constants and the trigger step function of the toggle sign mixer.
package tsmix_pkg;

  // Number of channels that have jacks, gains and lamps.
  localparam int NUM_JACKS = 4;

  // Field widths.
  localparam int SMP_W  = 16;
  localparam int GAIN_W = 4;
  localparam int LVL_W  = 16;
  localparam int LAMP_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // A signed sample times an unsigned 4-bit gain needs 21 bits.
  localparam int PROD_W = SMP_W + GAIN_W + 1;

  // Input beat layout, lowest bit first.
  localparam int IN_SMP_LSB = 0;
  localparam int IN_ADD_LSB = NUM_JACKS * SMP_W;
  localparam int IN_INV_LSB = IN_ADD_LSB + NUM_JACKS * LVL_W;
  localparam int IN_RST_LSB = IN_INV_LSB + NUM_JACKS * LVL_W;
  localparam int IN_DATA_W  = IN_RST_LSB + LVL_W;

  // Output beat layout, lowest bit first.
  localparam int OUT_SUM_LSB = 0;
  localparam int OUT_NEG_LSB = SMP_W;
  localparam int OUT_ADD_LSB = 2 * SMP_W;
  localparam int OUT_SUB_LSB = OUT_ADD_LSB + LAMP_W;
  localparam int OUT_DATA_W  = OUT_SUB_LSB + LAMP_W;

  // One volt in sample units, read on a channel whose jack is open.
  localparam logic signed [SMP_W-1:0] VOLT_ONE = 16'sd2048;

  // Saturation limit of the mixed sum (10 V).
  localparam int SUM_LIMIT = 20480;
  // Smallest magnitude of the raw sum that rounds to the limit or above:
  // 12 * SUM_LIMIT - 6.
  localparam int SAT_MAG = 245754;
  // ceil(2^17 / 3); floor(y * RECIP_3 / 2^17) equals floor(y / 3) for 16-bit y.
  localparam logic [16:0] RECIP_3 = 17'd43691;

  // Configuration register defaults.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd12;
  localparam logic signed [LVL_W-1:0] TRIG_HIGH_RESET = 16'sd2048;
  localparam logic signed [LVL_W-1:0] TRIG_LOW_RESET  = 16'sd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN0     = 3'd0,
    REG_GAIN1     = 3'd1,
    REG_GAIN2     = 3'd2,
    REG_GAIN3     = 3'd3,
    REG_CONNECTED = 3'd4,
    REG_TRIG_HIGH = 3'd5,
    REG_TRIG_LOW  = 3'd6
  } cfg_reg_t;

  // Hysteresis trigger state.
  typedef enum logic [1:0] {
    TRIG_UNKNOWN = 2'd0,
    TRIG_LOW     = 2'd1,
    TRIG_HIGH    = 2'd2
  } trig_t;

  // Channel mode.
  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ADD = 2'd1,
    MODE_SUB = 2'd2
  } mode_t;

  // Result of one trigger step: the new state and a rising edge flag.
  typedef struct packed {
    trig_t state;
    logic  fire;
  } trig_res_t;

  // Control from the top level to each channel.
  typedef struct packed {
    logic step;   // a beat moves through the mixing stage
    logic clear;  // the reset trigger fired on that beat
  } chan_ctrl_t;

  // One step of a hysteresis trigger. Only a low-to-high move fires.
  function automatic trig_res_t trig_step(
    input trig_t                   st,
    input logic signed [LVL_W-1:0] level,
    input logic signed [LVL_W-1:0] hi,
    input logic signed [LVL_W-1:0] lo
  );
    trig_res_t res;
    res.state = st;
    res.fire  = 1'b0;
    unique case (st)
      TRIG_LOW: begin
        if (level >= hi) begin
          res.state = TRIG_HIGH;
          res.fire  = 1'b1;
        end
      end
      TRIG_HIGH: begin
        if (level <= lo) begin
          res.state = TRIG_LOW;
        end
      end
      default: begin
        if (level >= hi) begin
          res.state = TRIG_HIGH;
        end else if (level <= lo) begin
          res.state = TRIG_LOW;
        end
      end
    endcase
    return res;
  endfunction

endpackage

/* sv/tsmix_chan.sv */
// One mixer channel: add and invert triggers, mode register and signed product.
module tsmix_chan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tsmix_pkg::chan_ctrl_t                ctrl,
  input  logic signed [tsmix_pkg::LVL_W-1:0]   trig_hi,
  input  logic signed [tsmix_pkg::LVL_W-1:0]   trig_lo,
  input  logic signed [tsmix_pkg::LVL_W-1:0]   add_level,
  input  logic signed [tsmix_pkg::LVL_W-1:0]   inv_level,
  input  logic signed [tsmix_pkg::SMP_W-1:0]   sample,
  input  logic                                 connected,
  input  logic        [tsmix_pkg::GAIN_W-1:0]  gain,
  output tsmix_pkg::mode_t                     mode_now,
  output logic signed [tsmix_pkg::PROD_W-1:0]  term
);

  tsmix_pkg::trig_t add_trig_r, add_trig_nxt;
  tsmix_pkg::trig_t invert_trig_r, invert_trig_nxt;
  tsmix_pkg::mode_t mode_r, mode_nxt;

  tsmix_pkg::trig_res_t add_res;
  tsmix_pkg::trig_res_t inv_res;
  tsmix_pkg::mode_t after_add;

  logic signed [tsmix_pkg::SMP_W-1:0]  smp_sel;
  logic signed [tsmix_pkg::GAIN_W:0]   gain_s;
  logic signed [tsmix_pkg::PROD_W-1:0] prod;

  // Trigger steps for this beat.
  always_comb begin
    add_res = tsmix_pkg::trig_step(add_trig_r, add_level, trig_hi, trig_lo);
    inv_res = tsmix_pkg::trig_step(invert_trig_r, inv_level, trig_hi, trig_lo);
  end

  // Add edge toggles add/off, then invert edge toggles subtract/off.
  always_comb begin
    after_add = mode_r;
    if (add_res.fire) begin
      after_add = (mode_r == tsmix_pkg::MODE_ADD) ? tsmix_pkg::MODE_OFF
                                                  : tsmix_pkg::MODE_ADD;
    end
    mode_now = after_add;
    if (inv_res.fire) begin
      mode_now = (after_add == tsmix_pkg::MODE_SUB) ? tsmix_pkg::MODE_OFF
                                                    : tsmix_pkg::MODE_SUB;
    end
  end

  // Stored state follows the beat; a reset trigger edge clears the mode
  // after this beat's mode has been used.
  always_comb begin
    add_trig_nxt    = add_trig_r;
    invert_trig_nxt = invert_trig_r;
    mode_nxt        = mode_r;
    if (ctrl.step) begin
      add_trig_nxt    = add_res.state;
      invert_trig_nxt = inv_res.state;
      mode_nxt        = ctrl.clear ? tsmix_pkg::MODE_OFF : mode_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_trig_r    <= tsmix_pkg::TRIG_UNKNOWN;
      invert_trig_r <= tsmix_pkg::TRIG_UNKNOWN;
      mode_r        <= tsmix_pkg::MODE_OFF;
    end else begin
      add_trig_r    <= add_trig_nxt;
      invert_trig_r <= invert_trig_nxt;
      mode_r        <= mode_nxt;
    end
  end

  // An open jack reads one volt. The product is signed by the mode.
  always_comb begin
    smp_sel = connected ? sample : tsmix_pkg::VOLT_ONE;
    gain_s  = $signed({1'b0, gain});
    prod    = tsmix_pkg::PROD_W'(smp_sel) * tsmix_pkg::PROD_W'(gain_s);
    unique case (mode_now)
      tsmix_pkg::MODE_ADD: term = prod;
      tsmix_pkg::MODE_SUB: term = -prod;
      default:             term = '0;
    endcase
  end

endmodule

/* sv/four_channel_toggle_sign_mixer.sv */
// Top level of the four-channel toggle sign mixer.
//
// Usage: each input beat carries four channel samples, the packed add and
// invert trigger levels of every channel and the reset trigger level. Each
// beat gives exactly one output beat with the saturated mixed sum, its
// negation and the add and subtract lamps of the channels.
// Gains, the jack connection mask and the trigger thresholds are to be written
// through the cfg_ port while no beat is in flight; the block does not enforce it.
//
// From the input register to out_tvalid a beat passes the mixing stage
// (triggers, modes, products and their sum) between the input register and
// the sum register, then the rounding stage (divide by twelve through a
// 16 by 17 bit reciprocal multiply, saturate, negate) that loads the
// output register.
// Throughput is one beat per cycle while the receiver keeps out_tready high;
// the channel modes are updated as a beat leaves the input register, so consecutive beats follow without a gap.
//
// Reset clears all modes to off, all triggers to the unknown state and the
// configuration registers to their defaults. When the receiver holds
// out_tready low, the three stages fill and then in_tready falls; nothing
// is dropped and the channel state advances only for beats that move on.
module four_channel_toggle_sign_mixer #(
  parameter int CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample_0, sample_1, sample_2, sample_3, add_trigger_levels,
  // invert_trigger_levels, reset_trigger_level
  input  logic [tsmix_pkg::IN_DATA_W-1:0]        in_tdata,
  // Result channel.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // mix_sum, mix_sum_negated, add_lamps, subtract_lamps
  output logic [tsmix_pkg::OUT_DATA_W-1:0]       out_tdata,
  // Configuration port.
  input  logic                                   cfg_wr_en,
  input  logic [tsmix_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsmix_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int ACC_W = tsmix_pkg::PROD_W + $clog2(CHANNELS);

  // Configuration registers.
  logic        [tsmix_pkg::GAIN_W-1:0] gain_r [tsmix_pkg::NUM_JACKS];
  logic        [tsmix_pkg::NUM_JACKS-1:0] conn_r;
  logic signed [tsmix_pkg::LVL_W-1:0]  trig_hi_r;
  logic signed [tsmix_pkg::LVL_W-1:0]  trig_lo_r;

  // Pipeline registers.
  logic                                  in_v_r;
  logic [tsmix_pkg::IN_DATA_W-1:0]       in_data_r;
  logic                                  mix_v_r;
  logic signed [ACC_W-1:0]               acc_r;
  logic [tsmix_pkg::LAMP_W-1:0]          add_lamp_r;
  logic [tsmix_pkg::LAMP_W-1:0]          sub_lamp_r;
  logic                                  out_v_r;
  logic [tsmix_pkg::OUT_DATA_W-1:0]      out_data_r;

  // Reset trigger.
  tsmix_pkg::trig_t     rst_trig_r, rst_trig_nxt;
  tsmix_pkg::trig_res_t rst_res;

  // Handshake.
  logic in_acc;
  logic mix_step;
  logic out_load;

  // Mixing stage signals.
  tsmix_pkg::chan_ctrl_t                chan_ctrl;
  tsmix_pkg::mode_t                     mode_now [CHANNELS];
  logic signed [tsmix_pkg::PROD_W-1:0]  term [CHANNELS];
  logic signed [ACC_W-1:0]              acc_sum;
  logic [tsmix_pkg::LAMP_W-1:0]         add_lamp;
  logic [tsmix_pkg::LAMP_W-1:0]         sub_lamp;

  // Rounding stage signals.
  logic [ACC_W-1:0]                     mag;
  logic [17:0]                          mag_rnd;
  logic [31:0]                          quot_prod;
  logic [tsmix_pkg::SMP_W-1:0]          quot;
  logic signed [tsmix_pkg::SMP_W-1:0]   sum_val;
  logic signed [tsmix_pkg::SMP_W-1:0]   neg_val;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsmix_pkg::NUM_JACKS; i++) begin
        gain_r[i] <= tsmix_pkg::GAIN_RESET;
      end
      conn_r    <= '0;
      trig_hi_r <= tsmix_pkg::TRIG_HIGH_RESET;
      trig_lo_r <= tsmix_pkg::TRIG_LOW_RESET;
    end else if (cfg_wr_en) begin
      unique case (tsmix_pkg::cfg_reg_t'(cfg_index))
        tsmix_pkg::REG_GAIN0:     gain_r[0] <= cfg_wdata[tsmix_pkg::GAIN_W-1:0];
        tsmix_pkg::REG_GAIN1:     gain_r[1] <= cfg_wdata[tsmix_pkg::GAIN_W-1:0];
        tsmix_pkg::REG_GAIN2:     gain_r[2] <= cfg_wdata[tsmix_pkg::GAIN_W-1:0];
        tsmix_pkg::REG_GAIN3:     gain_r[3] <= cfg_wdata[tsmix_pkg::GAIN_W-1:0];
        tsmix_pkg::REG_CONNECTED: conn_r    <= cfg_wdata[tsmix_pkg::NUM_JACKS-1:0];
        tsmix_pkg::REG_TRIG_HIGH: trig_hi_r <= $signed(cfg_wdata);
        tsmix_pkg::REG_TRIG_LOW:  trig_lo_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Stage flow: each stage moves when the next one is empty or moving.
  always_comb begin
    out_load  = mix_v_r && (!out_v_r || out_tready);
    mix_step  = in_v_r && (!mix_v_r || out_load);
    in_tready = !in_v_r || mix_step;
    in_acc    = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mix_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (mix_step) begin
        in_v_r <= 1'b0;
      end
      if (mix_step) begin
        mix_v_r <= 1'b1;
      end else if (out_load) begin
        mix_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_tdata;
    end
  end

  // Reset trigger; its edge clears the modes after this beat is mixed.
  always_comb begin
    rst_res = tsmix_pkg::trig_step(rst_trig_r,
                $signed(in_data_r[tsmix_pkg::IN_RST_LSB +: tsmix_pkg::LVL_W]),
                trig_hi_r, trig_lo_r);
    rst_trig_nxt    = mix_step ? rst_res.state : rst_trig_r;
    chan_ctrl.step  = mix_step;
    chan_ctrl.clear = rst_res.fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_trig_r <= tsmix_pkg::TRIG_UNKNOWN;
    end else begin
      rst_trig_r <= rst_trig_nxt;
    end
  end

  // Channels. Those past the jacks see zero levels, samples and gains.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    if (c < tsmix_pkg::NUM_JACKS) begin : g_jack
      tsmix_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (chan_ctrl),
        .trig_hi   (trig_hi_r),
        .trig_lo   (trig_lo_r),
        .add_level ($signed(in_data_r[tsmix_pkg::IN_ADD_LSB + c*tsmix_pkg::LVL_W
                                      +: tsmix_pkg::LVL_W])),
        .inv_level ($signed(in_data_r[tsmix_pkg::IN_INV_LSB + c*tsmix_pkg::LVL_W
                                      +: tsmix_pkg::LVL_W])),
        .sample    ($signed(in_data_r[tsmix_pkg::IN_SMP_LSB + c*tsmix_pkg::SMP_W
                                      +: tsmix_pkg::SMP_W])),
        .connected (conn_r[c]),
        .gain      (gain_r[c]),
        .mode_now  (mode_now[c]),
        .term      (term[c])
      );
    end else begin : g_spare
      tsmix_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (chan_ctrl),
        .trig_hi   (trig_hi_r),
        .trig_lo   (trig_lo_r),
        .add_level ('0),
        .inv_level ('0),
        .sample    ('0),
        .connected (1'b1),
        .gain      ('0),
        .mode_now  (mode_now[c]),
        .term      (term[c])
      );
    end
  end

  // Lamps of the jack channels that exist.
  for (genvar l = 0; l < tsmix_pkg::LAMP_W; l++) begin : g_lamp
    if (l < CHANNELS) begin : g_on
      assign add_lamp[l] = (mode_now[l] == tsmix_pkg::MODE_ADD);
      assign sub_lamp[l] = (mode_now[l] == tsmix_pkg::MODE_SUB);
    end else begin : g_off
      assign add_lamp[l] = 1'b0;
      assign sub_lamp[l] = 1'b0;
    end
  end

  // Sum of the signed channel products.
  always_comb begin
    acc_sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      acc_sum = acc_sum + ACC_W'(term[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (mix_step) begin
      acc_r      <= acc_sum;
      add_lamp_r <= add_lamp;
      sub_lamp_r <= sub_lamp;
    end
  end

  // Divide by twelve, round half away from zero, saturate to 10 V.
  // floor((mag + 6) / 12) is taken as floor(floor((mag + 6) / 4) / 3).
  always_comb begin
    mag       = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    mag_rnd   = mag[17:0] + 18'd6;
    quot_prod = 32'(mag_rnd[17:2]) * 32'(tsmix_pkg::RECIP_3);
    if (mag >= ACC_W'(tsmix_pkg::SAT_MAG)) begin
      quot = tsmix_pkg::SMP_W'(tsmix_pkg::SUM_LIMIT);
    end else begin
      quot = {1'b0, quot_prod[31:17]};
    end
    sum_val = acc_r[ACC_W-1] ? -$signed(quot) : $signed(quot);
    neg_val = -sum_val;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {sub_lamp_r, add_lamp_r, neg_val, sum_val};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // A beat held in the mixing stage keeps its sum while the output is full.
  a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mix_v_r && !out_load |=> mix_v_r && $stable(acc_r))
    else $error("mixing stage lost or changed a held beat");

  // The negated output is always the negation of the sum.
  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $signed(out_data_r[tsmix_pkg::OUT_NEG_LSB +: tsmix_pkg::SMP_W])
                == -$signed(out_data_r[tsmix_pkg::OUT_SUM_LSB +: tsmix_pkg::SMP_W]))
    else $error("negated sum does not match sum");

  // The sum stays within the saturation limits.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |->
      $signed(out_data_r[tsmix_pkg::OUT_SUM_LSB +: tsmix_pkg::SMP_W])
        <= $signed(tsmix_pkg::SMP_W'(tsmix_pkg::SUM_LIMIT)) &&
      $signed(out_data_r[tsmix_pkg::OUT_SUM_LSB +: tsmix_pkg::SMP_W])
        >= -$signed(tsmix_pkg::SMP_W'(tsmix_pkg::SUM_LIMIT)))
    else $error("mixed sum outside the saturation range");

  // A channel is never shown in add and subtract mode at once.
  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r[tsmix_pkg::OUT_ADD_LSB +: tsmix_pkg::LAMP_W] &
                 out_data_r[tsmix_pkg::OUT_SUB_LSB +: tsmix_pkg::LAMP_W]) == '0)
    else $error("add and subtract lamps overlap");

endmodule
